### rtl/core/ordered_list_position_engine_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ordered list position engine
// Shared concurrent assertion forms, clocked on clk, held off during arst_n.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_POSITION_ENGINE_ASSERT_SVH
`define ORDERED_LIST_POSITION_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define OLPE_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define OLPE_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/olpe_pkg.sv
// ----------------------------------------------------------------------------
// olpe_pkg
// Sizes, request and status codes and the result record of the list engine.
// ----------------------------------------------------------------------------
package olpe_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int REQ_W  = 3;
	localparam int POS_W  = 8;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 3;
	localparam int FPOS_W = 7;

	localparam logic [REQ_W-1:0] REQ_READ_ALL  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INS_FIRST = 3'd1;
	localparam logic [REQ_W-1:0] REQ_INS_LAST  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_INS_AT    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_DEL_FIRST = 3'd4;
	localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd5;
	localparam logic [REQ_W-1:0] REQ_DEL_AT    = 3'd6;
	localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd7;

	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd1;
	localparam logic [STAT_W-1:0] STAT_INVALID  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;

	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] value;
		logic [FPOS_W-1:0]       fpos;
		logic                    last;
	} res_t;

endpackage

### rtl/core/olpe_core.sv
// ----------------------------------------------------------------------------
// olpe_core
// Request sequencer around the element memory: decodes a request, walks the
// memory with at most one read or one write per cycle, and hands out result records.
// ----------------------------------------------------------------------------
module olpe_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 req_valid,
	input  logic [olpe_pkg::REQ_W-1:0]           req_type,
	input  logic [olpe_pkg::POS_W-1:0]           req_position,
	input  logic signed [olpe_pkg::VAL_W-1:0]    req_value,
	output logic                                 idle,
	input  logic                                 res_free,
	output logic                                 res_valid,
	output olpe_pkg::res_t                       res
);

	localparam int IDX_W = olpe_pkg::IDX_W;
	localparam int CNT_W = olpe_pkg::CNT_W;
	localparam int POS_W = olpe_pkg::POS_W;
	localparam int CMP_W = POS_W + 1;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_EMIT    = 4'd1;
	localparam logic [3:0] S_RA_RD   = 4'd2;
	localparam logic [3:0] S_RA_OUT  = 4'd3;
	localparam logic [3:0] S_INS_CHK = 4'd4;
	localparam logic [3:0] S_INS_WR  = 4'd5;
	localparam logic [3:0] S_DEL_RD  = 4'd6;
	localparam logic [3:0] S_DEL_CAP = 4'd7;
	localparam logic [3:0] S_DEL_CHK = 4'd8;
	localparam logic [3:0] S_DEL_WR  = 4'd9;
	localparam logic [3:0] S_SR_RD   = 4'd10;
	localparam logic [3:0] S_SR_CMP  = 4'd11;

	function automatic olpe_pkg::res_t status_res(input logic [olpe_pkg::STAT_W-1:0] st);
		olpe_pkg::res_t r;
		r.status = st;
		r.value  = '0;
		r.fpos   = '0;
		r.last   = 1'b1;
		return r;
	endfunction

	logic [3:0]                         state_q, state_d;
	logic [CNT_W-1:0]                   count_q, count_d;
	logic [IDX_W-1:0]                   ptr_q, ptr_d;
	logic [IDX_W-1:0]                   idx_q, idx_d;
	logic signed [olpe_pkg::VAL_W-1:0]  val_q, val_d;
	olpe_pkg::res_t                     res_q, res_d;

	logic signed [olpe_pkg::VAL_W-1:0]  mem_q [olpe_pkg::CAPACITY];
	logic signed [olpe_pkg::VAL_W-1:0]  rd_q;
	logic                               mem_re, mem_we;
	logic [IDX_W-1:0]                   mem_raddr, mem_waddr;
	logic signed [olpe_pkg::VAL_W-1:0]  mem_wdata;

	logic [CNT_W-1:0] ptr_plus;
	logic [CNT_W-1:0] cnt_m1;
	logic [POS_W-1:0] pos_m1;
	logic [CMP_W-1:0] pos_ext, cnt_ext;
	logic             empty, full, del_done;
	logic             pos_bad_ins, pos_bad_del;

	assign ptr_plus    = CNT_W'(ptr_q) + CNT_W'(1);
	assign cnt_m1      = count_q - CNT_W'(1);
	assign pos_m1      = req_position - POS_W'(1);
	assign pos_ext     = CMP_W'(req_position);
	assign cnt_ext     = CMP_W'(count_q);
	assign empty       = (count_q == '0);
	assign full        = (count_q == CNT_W'(olpe_pkg::CAPACITY));
	assign del_done    = (ptr_plus == count_q);
	assign pos_bad_ins = (req_position == '0) || (pos_ext > cnt_ext + CMP_W'(1));
	assign pos_bad_del = (req_position == '0) || (pos_ext > cnt_ext);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_EMIT) || (state_q == S_RA_OUT);

	always_comb begin
		res = res_q;
		if (state_q == S_RA_OUT) begin
			res.status = olpe_pkg::STAT_OK;
			res.value  = rd_q;
			res.fpos   = '0;
			res.last   = (ptr_plus == count_q);
		end
	end

	// memory port control
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = ptr_q;
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = rd_q;
		case (state_q)
			S_RA_RD, S_DEL_RD, S_SR_RD: begin
				mem_re = 1'b1;
			end
			S_INS_CHK: begin
				if (ptr_q != idx_q) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_q - 1'b1;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = idx_q;
					mem_wdata = val_q;
				end
			end
			S_INS_WR, S_DEL_WR: begin
				mem_we = 1'b1;
			end
			S_DEL_CHK: begin
				if (!del_done) begin
					mem_re    = 1'b1;
					mem_raddr = ptr_plus[IDX_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= mem_q[mem_raddr];
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		count_d = count_q;
		ptr_d   = ptr_q;
		idx_d   = idx_q;
		val_d   = val_q;
		res_d   = res_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					val_d = req_value;
					case (req_type)
						olpe_pkg::REQ_READ_ALL: begin
							if (empty) begin
								res_d   = status_res(olpe_pkg::STAT_EMPTY);
								state_d = S_EMIT;
							end else begin
								ptr_d   = '0;
								state_d = S_RA_RD;
							end
						end
						olpe_pkg::REQ_INS_FIRST, olpe_pkg::REQ_INS_LAST,
						olpe_pkg::REQ_INS_AT: begin
							if (req_type == olpe_pkg::REQ_INS_AT && pos_bad_ins) begin
								res_d   = status_res(olpe_pkg::STAT_INVALID);
								state_d = S_EMIT;
							end else if (full) begin
								res_d   = status_res(olpe_pkg::STAT_FULL);
								state_d = S_EMIT;
							end else begin
								ptr_d   = count_q[IDX_W-1:0];
								state_d = S_INS_CHK;
								case (req_type)
									olpe_pkg::REQ_INS_FIRST: idx_d = '0;
									olpe_pkg::REQ_INS_LAST:  idx_d = count_q[IDX_W-1:0];
									default:                 idx_d = pos_m1[IDX_W-1:0];
								endcase
							end
						end
						olpe_pkg::REQ_DEL_FIRST, olpe_pkg::REQ_DEL_LAST,
						olpe_pkg::REQ_DEL_AT: begin
							if (empty) begin
								res_d   = status_res(olpe_pkg::STAT_EMPTY);
								state_d = S_EMIT;
							end else if (req_type == olpe_pkg::REQ_DEL_AT && pos_bad_del) begin
								res_d   = status_res(olpe_pkg::STAT_INVALID);
								state_d = S_EMIT;
							end else begin
								state_d = S_DEL_RD;
								case (req_type)
									olpe_pkg::REQ_DEL_FIRST: ptr_d = '0;
									olpe_pkg::REQ_DEL_LAST:  ptr_d = cnt_m1[IDX_W-1:0];
									default:                 ptr_d = pos_m1[IDX_W-1:0];
								endcase
							end
						end
						olpe_pkg::REQ_SEARCH: begin
							if (empty) begin
								res_d   = status_res(olpe_pkg::STAT_EMPTY);
								state_d = S_EMIT;
							end else begin
								ptr_d   = '0;
								state_d = S_SR_RD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_EMIT: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			S_RA_RD: begin
				state_d = S_RA_OUT;
			end
			S_RA_OUT: begin
				if (res_free) begin
					if (ptr_plus == count_q) begin
						state_d = S_IDLE;
					end else begin
						ptr_d   = ptr_q + 1'b1;
						state_d = S_RA_RD;
					end
				end
			end
			S_INS_CHK: begin
				if (ptr_q == idx_q) begin
					count_d = count_q + 1'b1;
					res_d   = status_res(olpe_pkg::STAT_OK);
					state_d = S_EMIT;
				end else begin
					state_d = S_INS_WR;
				end
			end
			S_INS_WR: begin
				ptr_d   = ptr_q - 1'b1;
				state_d = S_INS_CHK;
			end
			S_DEL_RD: begin
				state_d = S_DEL_CAP;
			end
			S_DEL_CAP: begin
				res_d       = status_res(olpe_pkg::STAT_OK);
				res_d.value = rd_q;
				state_d     = S_DEL_CHK;
			end
			S_DEL_CHK: begin
				if (del_done) begin
					count_d = cnt_m1;
					state_d = S_EMIT;
				end else begin
					state_d = S_DEL_WR;
				end
			end
			S_DEL_WR: begin
				ptr_d   = ptr_q + 1'b1;
				state_d = S_DEL_CHK;
			end
			S_SR_RD: begin
				state_d = S_SR_CMP;
			end
			S_SR_CMP: begin
				if (rd_q == val_q) begin
					res_d      = status_res(olpe_pkg::STAT_OK);
					res_d.fpos = olpe_pkg::FPOS_W'(ptr_plus);
					state_d    = S_EMIT;
				end else if (ptr_plus == count_q) begin
					res_d   = status_res(olpe_pkg::STAT_NOTFOUND);
					state_d = S_EMIT;
				end else begin
					ptr_d   = ptr_q + 1'b1;
					state_d = S_SR_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		idx_q <= idx_d;
		val_q <= val_d;
		res_q <= res_d;
	end

`include "ordered_list_position_engine_assert.svh"

	`OLPE_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(olpe_pkg::CAPACITY), "count above capacity")
	`OLPE_ASSERT_NOW(a_read_in_list, mem_re, CNT_W'(mem_raddr) < count_q, "memory read beyond list")
	`OLPE_ASSERT_NOW(a_one_port_op, 1'b1, !(mem_re && mem_we), "read and write in one cycle")
	`OLPE_ASSERT_NEXT(a_ins_count, (state_q == S_INS_CHK) && (ptr_q == idx_q), count_q == $past(count_q) + 1'b1, "insert did not grow list")
	`OLPE_ASSERT_NOW(a_req_idle, req_valid, state_q == S_IDLE, "request taken while busy")

endmodule

### rtl/core/ordered_list_position_engine.sv
// ----------------------------------------------------------------------------
// ordered_list_position_engine
// Ordered list of signed 32-bit values with positional insert, delete,
// search and read-all requests, kept in a single-port memory.
// ----------------------------------------------------------------------------
// The engine takes one request at a time: in_stall is high from the edge a
// request is accepted until its last result has left the sequencer for the
// output register, so a new request can enter while a finished result still
// waits on out_stall. All work goes through one element memory that does
// either one read or one write per cycle, with a registered read port, and
// that port sets the cost. Error results and insert into a full list are
// answered from the request decode without touching the memory. Read-all
// reads each element in turn and hands it out; search reads and compares
// elements up to the hit, all n on a miss, with n the list count; an insert
// moves the elements from its slot to the tail up by one, starting at the
// tail, and then writes the new value; a delete reads and captures its
// element and then moves the ones above it down. The worst case is a delete
// at the head of a full list. Status codes: ok, list empty, invalid position,
// not found, list full. Every request ends with one result carrying last;
// read-all gives one result per element. No memory clearing pass is needed
// after reset: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_position_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [olpe_pkg::REQ_W-1:0]         req_type,
	input  logic [olpe_pkg::POS_W-1:0]         position,
	input  logic signed [olpe_pkg::VAL_W-1:0]  value,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [olpe_pkg::STAT_W-1:0]        status,
	output logic signed [olpe_pkg::VAL_W-1:0]  value_out,
	output logic [olpe_pkg::FPOS_W-1:0]        found_position,
	output logic                               last
);

	logic           core_idle;
	logic           req_accept;
	logic           res_valid;
	logic           res_free;
	olpe_pkg::res_t res;

	logic           out_valid_q;
	olpe_pkg::res_t out_res_q;

	// a request is taken only while the sequencer sits idle
	assign in_stall   = !core_idle;
	assign req_accept = in_valid && !in_stall;

	// output register is free when empty or being drained this cycle
	assign res_free = !out_valid_q || !out_stall;

	olpe_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_accept),
		.req_type     (req_type),
		.req_position (position),
		.req_value    (value),
		.idle         (core_idle),
		.res_free     (res_free),
		.res_valid    (res_valid),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_free) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			out_res_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_res_q.status;
	assign value_out      = out_res_q.value;
	assign found_position = out_res_q.fpos;
	assign last           = out_res_q.last;

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the ordered list position engine
// Drives list requests on the valid/stall request channel and checks every
// result against a shadow copy of the list kept in a small class. A short
// directed run covers the empty, invalid-position, append, repeat and miss
// cases. Random bursts then grow and drain the list so it fills up and
// empties again. Idling on both channels changes over three phases.
// ----------------------------------------------------------------------------
module tb_top;
	import olpe_pkg::*;

	// Shadow copy of the list. Every accepted request is applied here first,
	// and the results the engine owes are queued in order.
	class list_mirror;
		logic signed [VAL_W-1:0] slots [CAPACITY];
		int unsigned             count;
		res_t                    owed [$];
		int                      mismatches;

		function new();
			count      = 0;
			mismatches = 0;
		endfunction

		// One line per mismatch.
		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		function void owe(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] v,
				logic [FPOS_W-1:0] fp, logic lst);
			res_t r;
			r.status = st;
			r.value  = v;
			r.fpos   = fp;
			r.last   = lst;
			owed.push_back(r);
		endfunction

		// Shift the tail up and drop v in at 0-based idx.
		function void insert_at(int unsigned idx, logic signed [VAL_W-1:0] v);
			for (int unsigned i = count; i > idx; i--) begin
				slots[i] = slots[i - 1];
			end
			slots[idx] = v;
			count++;
			owe(STAT_OK, '0, '0, 1'b1);
		endfunction

		// Pull the entry at 0-based idx and close the gap.
		function void remove_at(int unsigned idx);
			logic signed [VAL_W-1:0] v;
			v = slots[idx];
			for (int unsigned i = idx; i + 1 < count; i++) begin
				slots[i] = slots[i + 1];
			end
			count--;
			owe(STAT_OK, v, '0, 1'b1);
		endfunction

		function void take_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
				logic signed [VAL_W-1:0] val);
			int unsigned p;
			int unsigned hit;
			p   = pos;
			hit = 0;
			case (kind)
				REQ_READ_ALL: begin
					if (count == 0) begin
						owe(STAT_EMPTY, '0, '0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < count; i++) begin
							owe(STAT_OK, slots[i], '0, (i + 1 == count));
						end
					end
				end
				REQ_INS_FIRST, REQ_INS_LAST: begin
					if (count >= CAPACITY) begin
						owe(STAT_FULL, '0, '0, 1'b1);
					end else begin
						insert_at((kind == REQ_INS_FIRST) ? 0 : count, val);
					end
				end
				REQ_INS_AT: begin
					// position is judged before fullness
					if (p < 1 || p > count + 1) begin
						owe(STAT_INVALID, '0, '0, 1'b1);
					end else if (count >= CAPACITY) begin
						owe(STAT_FULL, '0, '0, 1'b1);
					end else begin
						insert_at(p - 1, val);
					end
				end
				REQ_DEL_FIRST, REQ_DEL_LAST: begin
					if (count == 0) begin
						owe(STAT_EMPTY, '0, '0, 1'b1);
					end else begin
						remove_at((kind == REQ_DEL_FIRST) ? 0 : count - 1);
					end
				end
				REQ_DEL_AT: begin
					if (count == 0) begin
						owe(STAT_EMPTY, '0, '0, 1'b1);
					end else if (p < 1 || p > count) begin
						owe(STAT_INVALID, '0, '0, 1'b1);
					end else begin
						remove_at(p - 1);
					end
				end
				default: begin
					// search: first matching position wins
					if (count == 0) begin
						owe(STAT_EMPTY, '0, '0, 1'b1);
					end else begin
						for (int unsigned i = 0; i < count; i++) begin
							if (hit == 0 && slots[i] == val) begin
								hit = i + 1;
							end
						end
						if (hit != 0) begin
							owe(STAT_OK, '0, FPOS_W'(hit), 1'b1);
						end else begin
							owe(STAT_NOTFOUND, '0, '0, 1'b1);
						end
					end
				end
			endcase
		endfunction

		task check_result(logic [STAT_W-1:0] st, logic signed [VAL_W-1:0] v,
				logic [FPOS_W-1:0] fp, logic lst);
			res_t e;
			if (owed.size() == 0) begin
				report($sformatf("result with nothing owed: status %0d value %0d fpos %0d last %0b",
					st, v, fp, lst));
				return;
			end
			e = owed.pop_front();
			if (st !== e.status) begin
				report($sformatf("status %0d, want %0d", st, e.status));
			end
			if (v !== e.value) begin
				report($sformatf("value_out %0d, want %0d", v, e.value));
			end
			if (fp !== e.fpos) begin
				report($sformatf("found_position %0d, want %0d", fp, e.fpos));
			end
			if (lst !== e.last) begin
				report($sformatf("last %0b, want %0b", lst, e.last));
			end
		endtask
	endclass

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_LIMIT = 100000;
	// tail wait after the drain, sized at four worst-case requests
	localparam int TAIL_CYCLES = 4 * (2 * CAPACITY + 4);

	localparam int NUM_PHASES = 3;
	// sender idles 30%, receiver 64%; then swapped; then no idling at all
	localparam int SEND_IDLE [NUM_PHASES] = '{30, 64, 0};
	localparam int RECV_IDLE [NUM_PHASES] = '{64, 30, 0};
	localparam int PHASE_ITEMS [NUM_PHASES] = '{170, 170, 160};

	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    in_valid  = 1'b0;
	logic                    in_stall;
	logic [REQ_W-1:0]        req_type  = REQ_READ_ALL;
	logic [POS_W-1:0]        position  = '0;
	logic signed [VAL_W-1:0] value     = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] value_out;
	logic [FPOS_W-1:0]       found_position;
	logic                    last;

	int          send_idle_pct = SEND_IDLE[0];
	int          recv_idle_pct = RECV_IDLE[0];
	int unsigned cycles        = 0;
	list_mirror  mirror;

	ordered_list_position_engine dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.position       (position),
		.value          (value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.value_out      (value_out),
		.found_position (found_position),
		.last           (last)
	);

	always #6 clk = ~clk;

	// Run guard: a hung engine ends the run here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// Result side: take a result whenever valid meets a low stall, then pick
	// the stall for the next cycle at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			mirror.check_result(status, value_out, found_position, last);
		end
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Present one request and hold it until the engine takes it. Called right
	// after an edge, so in_valid gets a single assignment per time step: either
	// lowered for an idle cycle or kept high with the next request.
	task automatic send_request(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
			logic signed [VAL_W-1:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		position <= pos;
		value    <= val;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		mirror.take_request(kind, pos, val);
	endtask

	initial begin
		int unsigned             n;
		int unsigned             roll;
		int unsigned             burst_left;
		bit                      growing;
		logic [REQ_W-1:0]        kind;
		logic [POS_W-1:0]        pos;
		logic signed [VAL_W-1:0] val;
		int                      waited;

		mirror     = new();
		burst_left = 0;
		growing    = 1'b0;
		waited     = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// everything on an empty list
		send_request(REQ_READ_ALL, 8'd0, 32'sd0);
		send_request(REQ_DEL_FIRST, 8'd0, 32'sd0);
		send_request(REQ_DEL_LAST, 8'd0, 32'sd0);
		send_request(REQ_DEL_AT, 8'd1, 32'sd0);
		send_request(REQ_SEARCH, 8'd0, 32'sd0);
		// insert-at position zero and one past count+1
		send_request(REQ_INS_AT, 8'd0, 32'sd7);
		send_request(REQ_INS_AT, 8'd2, 32'sd7);
		// value extremes, append through count+1, insert in the middle
		send_request(REQ_INS_AT, 8'd1, 32'sh80000000);
		send_request(REQ_INS_FIRST, 8'd0, 32'sh7FFFFFFF);
		send_request(REQ_INS_LAST, 8'd0, -32'sd1);
		send_request(REQ_INS_AT, 8'd4, 32'sd0);
		send_request(REQ_INS_AT, 8'd2, 32'sh5A5A5A5A);
		// repeated value: search must report the first one
		send_request(REQ_INS_LAST, 8'd0, 32'sh7FFFFFFF);
		send_request(REQ_SEARCH, 8'hFF, 32'sh7FFFFFFF);
		send_request(REQ_SEARCH, 8'd0, 32'sd0);
		send_request(REQ_SEARCH, 8'd0, 32'sd12345);
		// bad delete and insert positions on a non-empty list
		send_request(REQ_DEL_AT, 8'd0, 32'sd0);
		send_request(REQ_DEL_AT, 8'd7, 32'sd0);
		send_request(REQ_INS_AT, 8'd255, 32'sd1);
		send_request(REQ_READ_ALL, 8'd0, 32'sd0);
		send_request(REQ_DEL_AT, 8'd3, 32'sd0);
		send_request(REQ_DEL_FIRST, 8'd0, 32'sd0);
		send_request(REQ_DEL_LAST, 8'd0, 32'sd0);
		send_request(REQ_READ_ALL, 8'd0, 32'sd0);

		// --- random part ---
		// Bursts alternate between growing and draining so the list keeps
		// hitting both full and empty; a slice of each burst is pure noise.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			send_idle_pct = SEND_IDLE[ph];
			recv_idle_pct = RECV_IDLE[ph];
			for (int k = 0; k < PHASE_ITEMS[ph]; k++) begin
				if (burst_left == 0) begin
					growing    = !growing;
					burst_left = $urandom_range(10, 40);
				end
				burst_left--;
				n    = mirror.count;
				roll = $urandom_range(99);
				if (roll < 75) begin
					if (growing) begin
						case ($urandom_range(2))
							0: kind = REQ_INS_FIRST;
							1: kind = REQ_INS_LAST;
							default: kind = REQ_INS_AT;
						endcase
					end else begin
						case ($urandom_range(2))
							0: kind = REQ_DEL_FIRST;
							1: kind = REQ_DEL_LAST;
							default: kind = REQ_DEL_AT;
						endcase
					end
				end else if (roll < 80) begin
					kind = growing ? REQ_DEL_AT : REQ_INS_AT;
				end else if (roll < 90) begin
					kind = REQ_SEARCH;
				end else if (roll < 95) begin
					kind = REQ_READ_ALL;
				end else begin
					kind = REQ_W'($urandom_range(7));
				end

				// mostly legal positions, sometimes anything the field holds
				if (kind == REQ_INS_AT && $urandom_range(99) < 80) begin
					pos = POS_W'($urandom_range(1, n + 1));
				end else if (kind == REQ_DEL_AT && n > 0 && $urandom_range(99) < 80) begin
					pos = POS_W'($urandom_range(1, n));
				end else begin
					pos = POS_W'($urandom_range(255));
				end

				// searches mostly hit; inserts sometimes reuse a small pool
				// so repeats and extremes show up in the list
				if (kind == REQ_SEARCH && n > 0 && $urandom_range(99) < 60) begin
					val = mirror.slots[$urandom_range(n - 1)];
				end else if ($urandom_range(99) < 25) begin
					case ($urandom_range(4))
						0: val = 32'sh80000000;
						1: val = 32'sh7FFFFFFF;
						2: val = -32'sd1;
						3: val = 32'sd0;
						default: val = $urandom_range(1, 3);
					endcase
				end else begin
					val = $urandom;
				end

				send_request(kind, pos, val);
			end
		end
		in_valid <= 1'b0;

		// let the owed results come home, then watch for strays
		while (mirror.owed.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mirror.owed.size() != 0) begin
			mirror.report($sformatf("%0d results never arrived", mirror.owed.size()));
		end

		if (mirror.mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
